// ===== rtl/core/afv_pkg.sv =====
// Package for the box versus frustum visibility block.
// Holds register indexes, result codes and fixed-point constants; no dependencies.
`default_nettype none

package afv_pkg;

    localparam int DEF_MAX_PLANES   = 6;
    localparam int DEF_COORD_BITS   = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_BITS      = 16;
    localparam int DIST_BITS        = 16;
    localparam int PLANE_BITS       = 64;
    localparam int MASK_BITS        = 32;
    localparam int COUNT_BITS       = 3;
    localparam int CFG_INDEX_BITS   = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PLANE_COUNT = 3'd0,
        CFG_VIEW_MASK   = 3'd1,
        CFG_PLANE_0     = 3'd2,
        CFG_PLANE_1     = 3'd3,
        CFG_PLANE_2     = 3'd4,
        CFG_PLANE_3     = 3'd5,
        CFG_PLANE_4     = 3'd6,
        CFG_PLANE_5     = 3'd7
    } t_cfg_index;

    typedef enum logic [1:0] {
        VIS_UNKNOWN = 2'd0,
        VIS_VISIBLE = 2'd1,
        VIS_HIDDEN  = 2'd2
    } t_vis;

    localparam logic [COUNT_BITS-1:0] RST_PLANE_COUNT = 3'd6;
    localparam logic [MASK_BITS-1:0]  RST_VIEW_MASK   = 32'hFFFF_FFFF;
    localparam logic [PLANE_BITS-1:0] RST_PLANE       = 64'd0;

endpackage

`default_nettype wire

// ===== rtl/core/afv_plane_test.sv =====
// One frustum plane lane: positive-vertex select, product register, sum and sign test.
// Depends on afv_pkg for the plane layout and fixed-point constants.
`default_nettype none

module afv_plane_test
    import afv_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire logic [PLANE_BITS-1:0]        i_plane,
    input  wire logic [2:0][COORD_BITS-1:0]   i_lo,
    input  wire logic [2:0][COORD_BITS-1:0]   i_hi,
    output logic                              o_reject
);

    localparam int PW  = COORD_BITS + NORMAL_BITS;
    localparam int DSW = DIST_BITS + NORMAL_FRAC_BITS;
    localparam int SW  = ((PW > DSW) ? PW : DSW) + 2;

    logic signed [NORMAL_BITS-1:0] w_n [3];
    logic signed [COORD_BITS-1:0]  w_c [3];
    logic signed [PW-1:0]          n_prod [3];
    logic signed [PW-1:0]          r_prod [3];
    logic signed [DIST_BITS-1:0]   r_dist;
    logic signed [SW-1:0]          w_dist;
    logic signed [SW-1:0]          w_sum;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_n[a]    = $signed(i_plane[NORMAL_BITS*a +: NORMAL_BITS]);
            w_c[a]    = w_n[a][NORMAL_BITS-1] ? $signed(i_lo[a]) : $signed(i_hi[a]);
            n_prod[a] = PW'(w_n[a]) * PW'(w_c[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= n_prod[a];
            end
            r_dist <= $signed(i_plane[PLANE_BITS-1 -: DIST_BITS]);
        end
    end

    always_comb begin
        w_dist   = SW'(r_dist) <<< NORMAL_FRAC_BITS;
        w_sum    = SW'(r_prod[0]) + SW'(r_prod[1]) + SW'(r_prod[2]) + w_dist;
        o_reject = w_sum[SW-1];
    end

endmodule

`default_nettype wire

// ===== rtl/core/aabb_frustum_visibility.sv =====
// Top level of the box versus frustum visibility classifier.
// Depends on afv_pkg and afv_plane_test (one instance per plane).
//
// Takes one box word per cycle while the output side does not stall it, and returns one
// visibility word per box, in order. A box passes the input register, the per-plane
// product registers and the result register. Each plane lane has its own three
// multipliers, so all planes are tested at once; products are registered, then summed
// and sign-tested before the result register.
// Configuration must be written with no box in flight; the configuration port is
// always ready.
`default_nettype none

module aabb_frustum_visibility
    import afv_pkg::*;
#(
    parameter int MAX_PLANES = DEF_MAX_PLANES,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [PLANE_BITS-1:0]      i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [COORD_BITS-1:0]      i_min_x,
    input  wire logic [COORD_BITS-1:0]      i_min_y,
    input  wire logic [COORD_BITS-1:0]      i_min_z,
    input  wire logic [COORD_BITS-1:0]      i_max_x,
    input  wire logic [COORD_BITS-1:0]      i_max_y,
    input  wire logic [COORD_BITS-1:0]      i_max_z,
    input  wire logic [MASK_BITS-1:0]       i_probe_mask,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_visibility
);

    localparam logic [COUNT_BITS-1:0] MAXP = COUNT_BITS'(MAX_PLANES);

    logic [COUNT_BITS-1:0]            r_plane_count;
    logic [MASK_BITS-1:0]             r_view_mask;
    logic [MAX_PLANES-1:0][PLANE_BITS-1:0] r_plane;

    logic                             r_v1, r_v2, r_v3;
    logic                             r_hit1, r_hit2;
    logic [2:0][COORD_BITS-1:0]       r_lo, r_hi;
    t_vis                             r_vis;
    t_vis                             n_vis;

    logic                             w_rdy1, w_rdy2, w_rdy3;
    logic                             w_accept;
    logic [COUNT_BITS-1:0]            w_count;
    logic [MAX_PLANES-1:0]            w_en;
    logic [MAX_PLANES-1:0]            w_reject;

    assign o_cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_count <= RST_PLANE_COUNT;
            r_view_mask   <= RST_VIEW_MASK;
            for (int p = 0; p < MAX_PLANES; p++) begin
                r_plane[p] <= RST_PLANE;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PLANE_COUNT: r_plane_count <= i_cfg_data[COUNT_BITS-1:0];
                CFG_VIEW_MASK:   r_view_mask   <= i_cfg_data[MASK_BITS-1:0];
                default: begin
                    for (int p = 0; p < MAX_PLANES; p++) begin
                        if (i_cfg_index == CFG_INDEX_BITS'(int'(CFG_PLANE_0) + p)) begin
                            r_plane[p] <= i_cfg_data;
                        end
                    end
                end
            endcase
        end
    end

    // pipeline flow
    assign w_rdy3     = !r_v3 || i_out_ready;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;
    assign w_accept   = i_in_valid && w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lo   <= {i_min_z, i_min_y, i_min_x};
            r_hi   <= {i_max_z, i_max_y, i_max_x};
            r_hit1 <= |(i_probe_mask & r_view_mask);
        end
        if (w_rdy2) r_hit2 <= r_hit1;
        if (w_rdy3) r_vis  <= n_vis;
    end

    for (genvar p = 0; p < MAX_PLANES; p++) begin : g_plane
        afv_plane_test #(
            .COORD_BITS (COORD_BITS)
        ) u_plane (
            .i_clk    (i_clk),
            .i_load   (w_rdy2),
            .i_plane  (r_plane[p]),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .o_reject (w_reject[p])
        );
    end

    always_comb begin
        w_count = (r_plane_count > MAXP) ? MAXP : r_plane_count;
        for (int p = 0; p < MAX_PLANES; p++) begin
            w_en[p] = (COUNT_BITS'(p) < w_count);
        end
        if (!r_hit2) begin
            n_vis = VIS_UNKNOWN;
        end else if (|(w_reject & w_en)) begin
            n_vis = VIS_HIDDEN;
        end else begin
            n_vis = VIS_VISIBLE;
        end
    end

    assign o_out_valid  = r_v3;
    assign o_visibility = r_vis;

`ifndef SYNTHESIS
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted with full pipeline stalled");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && w_rdy2) |=> r_v2)
        else $error("word lost between first and second stage");

    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_rdy3 && !r_hit2) |=> (o_visibility == VIS_UNKNOWN))
        else $error("disjoint masks did not give unknown");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_aabb_frustum_visibility.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for aabb_frustum_visibility: a directed script, then random views.
// Depends on afv_pkg and the RTL; predicts untyped boxes with its own plane tests, typed ones from the script.

module tb_aabb_frustum_visibility;
    import afv_pkg::*;

    typedef struct packed {
        logic signed [15:0] min_x, min_y, min_z, max_x, max_y, max_z;
        logic [MASK_BITS-1:0] mask;
    } box_t;

    typedef enum logic {ROW_CFG, ROW_BOX} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        t_cfg_index            idx;
        logic [PLANE_BITS-1:0] data;
        box_t                  box;
        logic                  typed;
        t_vis                  vis;
    } row_t;

    localparam logic [PLANE_BITS-1:0] BEHIND_ONLY = {16'hFFFF, 48'd0};
    localparam int RAND_VIEWS = 10;
    localparam int BOXES_PER_VIEW = 40;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [PLANE_BITS-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [15:0]               i_min_x, i_min_y, i_min_z, i_max_x, i_max_y, i_max_z;
    logic [MASK_BITS-1:0]      i_probe_mask;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [1:0]                o_visibility;

    logic [COUNT_BITS-1:0] cur_plane_count;
    logic [MASK_BITS-1:0]  cur_view_mask;
    logic [PLANE_BITS-1:0] cur_planes [DEF_MAX_PLANES];

    row_t script [$];
    t_vis pending_vis [$];
    t_vis exp_vis;
    int   errors = 0;
    int   n_boxes = 0;
    int   n_class [3] = '{0, 0, 0};
    bit   idle_on = 1'b1;
    int   stall_left = 0;

    aabb_frustum_visibility u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_min_x      (i_min_x),
        .i_min_y      (i_min_y),
        .i_min_z      (i_min_z),
        .i_max_x      (i_max_x),
        .i_max_y      (i_max_y),
        .i_max_z      (i_max_z),
        .i_probe_mask (i_probe_mask),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_visibility (o_visibility)
    );

    always #2 i_clk = ~i_clk;

    // mask overlap check, then positive-vertex test against each enabled plane of the current view
    function automatic t_vis classify_box(box_t b);
        longint lo [3];
        longint hi [3];
        longint sum;
        longint nrm;
        int     used;
        if ((b.mask & cur_view_mask) == '0) return VIS_UNKNOWN;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        used = (cur_plane_count > DEF_MAX_PLANES) ? DEF_MAX_PLANES : int'(cur_plane_count);
        for (int p = 0; p < used; p++) begin
            sum = longint'($signed(cur_planes[p][63:48])) * (longint'(1) << NORMAL_FRAC_BITS);
            for (int a = 0; a < 3; a++) begin
                nrm = longint'($signed(cur_planes[p][16*a +: 16]));
                sum += nrm * ((nrm >= 0) ? hi[a] : lo[a]);
            end
            if (sum < 0) return VIS_HIDDEN;
        end
        return VIS_VISIBLE;
    endfunction

    function automatic void add_cfg(t_cfg_index idx, logic [PLANE_BITS-1:0] data);
        row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        script.push_back(r);
    endfunction

    function automatic void add_box(int mnx, int mny, int mnz, int mxx, int mxy, int mxz,
                                    logic [MASK_BITS-1:0] m, bit typed, t_vis v);
        row_t r;
        r = '0;
        r.kind = ROW_BOX;
        r.box.min_x = 16'(mnx);
        r.box.min_y = 16'(mny);
        r.box.min_z = 16'(mnz);
        r.box.max_x = 16'(mxx);
        r.box.max_y = 16'(mxy);
        r.box.max_z = 16'(mxz);
        r.box.mask = m;
        r.typed = typed;
        r.vis = v;
        script.push_back(r);
    endfunction

    function automatic logic signed [15:0] corner_pick();
        case ($urandom_range(0, 4))
            0: return 16'sh8000;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sh7FFF;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic cfg_write(t_cfg_index idx, logic [PLANE_BITS-1:0] data);
        if (i_in_valid) i_in_valid <= 1'b0;
        while (pending_vis.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PLANE_COUNT: cur_plane_count = data[COUNT_BITS-1:0];
            CFG_VIEW_MASK:   cur_view_mask = data[MASK_BITS-1:0];
            default:         cur_planes[idx - CFG_PLANE_0] = data;
        endcase
        @(negedge i_clk);
    endtask

    task automatic send_box(box_t b, bit typed, t_vis want);
        if (i_cfg_valid) i_cfg_valid <= 1'b0;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_min_x <= b.min_x;
        i_min_y <= b.min_y;
        i_min_z <= b.min_z;
        i_max_x <= b.max_x;
        i_max_y <= b.max_y;
        i_max_z <= b.max_z;
        i_probe_mask <= b.mask;
        do @(posedge i_clk); while (!o_in_ready);
        pending_vis.push_back(typed ? want : classify_box(b));
        n_boxes++;
        @(negedge i_clk);
    endtask

    // output side stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_vis.size() == 0) begin
                $display("%0t: visibility word %0d with none expected", $time, o_visibility);
                errors++;
            end else begin
                exp_vis = pending_vis.pop_front();
                if (o_visibility !== exp_vis) begin
                    $display("%0t: visibility mismatch, expected %0d, actual %0d",
                             $time, exp_vis, o_visibility);
                    errors++;
                end
                if (exp_vis <= VIS_HIDDEN) n_class[exp_vis]++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        box_t                 b;
        logic signed [15:0]   lo3 [3];
        logic signed [15:0]   hi3 [3];
        logic [MASK_BITS-1:0] vm;
        int                   c, e, pstyle, nx, ny, nz, dd;

        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PLANE_COUNT;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_min_x = '0;
        i_min_y = '0;
        i_min_z = '0;
        i_max_x = '0;
        i_max_y = '0;
        i_max_z = '0;
        i_probe_mask = '0;
        i_out_ready = 1'b0;
        cur_plane_count = RST_PLANE_COUNT;
        cur_view_mask = RST_VIEW_MASK;
        foreach (cur_planes[p]) cur_planes[p] = RST_PLANE;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset view: all planes zero, so any overlapping mask is visible
        add_box(-32768, -32768, -32768, 32767, 32767, 32767, '1, 1, VIS_VISIBLE);
        add_box(-32768, -32768, -32768, 32767, 32767, 32767, 32'h0, 1, VIS_UNKNOWN);
        add_box(32767, 32767, 32767, -32768, -32768, -32768, 32'h8000_0000, 1, VIS_VISIBLE);
        add_cfg(CFG_VIEW_MASK, 64'h0);
        add_box(0, 0, 0, 0, 0, 0, '1, 1, VIS_UNKNOWN);
        add_cfg(CFG_VIEW_MASK, 64'h1);
        add_box(-1, -1, -1, 1, 1, 1, 32'hFFFF_FFFE, 1, VIS_UNKNOWN);
        add_box(-1, -1, -1, 1, 1, 1, 32'h1, 1, VIS_VISIBLE);
        // zero normal with negative distance rejects everything
        add_cfg(CFG_PLANE_0, BEHIND_ONLY);
        add_box(-32768, -32768, -32768, 32767, 32767, 32767, 32'h1, 1, VIS_HIDDEN);
        add_cfg(CFG_PLANE_COUNT, 64'd0);
        add_box(-32768, -32768, -32768, 32767, 32767, 32767, 32'h1, 1, VIS_VISIBLE);
        add_cfg(CFG_PLANE_COUNT, 64'd1);
        add_box(-32768, -32768, -32768, 32767, 32767, 32767, 32'h1, 1, VIS_HIDDEN);
        // count 7 saturates to six planes
        add_cfg(CFG_PLANE_0, 64'd0);
        add_cfg(CFG_PLANE_5, BEHIND_ONLY);
        add_cfg(CFG_PLANE_COUNT, 64'd7);
        add_box(5, 5, 5, 6, 6, 6, 32'hFFFF_FFFF, 1, VIS_HIDDEN);
        add_cfg(CFG_PLANE_COUNT, 64'd5);
        add_box(5, 5, 5, 6, 6, 6, 32'hFFFF_FFFF, 1, VIS_VISIBLE);
        // extreme plane values
        add_cfg(CFG_VIEW_MASK, 64'hFFFF_FFFF);
        add_cfg(CFG_PLANE_COUNT, 64'd6);
        add_cfg(CFG_PLANE_0, {16'h7FFF, 16'h0000, 16'h8000, 16'h7FFF});
        add_cfg(CFG_PLANE_1, {16'h0000, 16'h4000, 16'h7FFF, 16'h8000});
        add_cfg(CFG_PLANE_2, {16'h8000, 16'hC000, 16'h0000, 16'hC000});
        add_cfg(CFG_PLANE_3, {16'h0001, 16'h4000, 16'h4000, 16'h4000});
        add_cfg(CFG_PLANE_4, 64'hFFFF_FFFF_FFFF_FFFF);
        add_cfg(CFG_PLANE_5, 64'd0);
        add_box(-32768, -32768, -32768, 32767, 32767, 32767, '1, 0, VIS_UNKNOWN);
        add_box(32767, 32767, 32767, -32768, -32768, -32768, '1, 0, VIS_UNKNOWN);
        add_box(0, 0, 0, 0, 0, 0, '1, 0, VIS_UNKNOWN);
        add_box(-32768, -32768, -32768, -32768, -32768, -32768, '1, 0, VIS_UNKNOWN);
        add_box(32767, 32767, 32767, 32767, 32767, 32767, '1, 0, VIS_UNKNOWN);
        add_box(100, 100, 100, 200, 200, 200, 32'h0000_0100, 0, VIS_UNKNOWN);
        add_box(-1, -1, -1, 0, 0, 0, '1, 0, VIS_UNKNOWN);
        add_box(-20000, 5, -7, -100, 30000, 8, '1, 0, VIS_UNKNOWN);
        add_box(-32768, 0, 32767, 32767, 0, -32768, '1, 0, VIS_UNKNOWN);

        foreach (script[r]) begin
            if (script[r].kind == ROW_CFG) cfg_write(script[r].idx, script[r].data);
            else send_box(script[r].box, script[r].typed, script[r].vis);
        end

        for (int v = 0; v < RAND_VIEWS; v++) begin
            idle_on = (v == RAND_VIEWS - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            cfg_write(CFG_PLANE_COUNT, {$urandom(), $urandom()});
            case ($urandom_range(0, 3))
                0: vm = '1;
                1: vm = $urandom();
                2: vm = 32'h1 << $urandom_range(0, 31);
                default: vm = $urandom() & $urandom();
            endcase
            cfg_write(CFG_VIEW_MASK, {$urandom(), vm});
            pstyle = $urandom_range(0, 2);
            for (int p = 0; p < DEF_MAX_PLANES; p++) begin
                if (pstyle == 0 || (pstyle == 2 && $urandom_range(0, 1) == 0)) begin
                    cfg_write(t_cfg_index'(CFG_PLANE_0 + p), {$urandom(), $urandom()});
                end else begin
                    // unit-ish normals, mostly positive distance: a plausible frustum
                    nx = int'($urandom_range(0, 32768)) - 16384;
                    ny = int'($urandom_range(0, 32768)) - 16384;
                    nz = int'($urandom_range(0, 32768)) - 16384;
                    dd = int'($urandom_range(0, 12000)) - 2000;
                    cfg_write(t_cfg_index'(CFG_PLANE_0 + p),
                              {16'(dd), 16'(nz), 16'(ny), 16'(nx)});
                end
            end

            for (int k = 0; k < BOXES_PER_VIEW; k++) begin
                pstyle = $urandom_range(0, 3);
                for (int a = 0; a < 3; a++) begin
                    case (pstyle)
                        0: begin
                            lo3[a] = 16'($urandom());
                            hi3[a] = 16'($urandom());
                        end
                        1: begin
                            lo3[a] = 16'($urandom());
                            hi3[a] = 16'($urandom());
                            if (lo3[a] > hi3[a]) begin
                                c = lo3[a];
                                lo3[a] = hi3[a];
                                hi3[a] = 16'(c);
                            end
                        end
                        2: begin
                            c = int'($urandom_range(0, 8000)) - 4000;
                            e = $urandom_range(0, 300);
                            lo3[a] = 16'(c - e);
                            hi3[a] = 16'(c + e);
                        end
                        default: begin
                            lo3[a] = corner_pick();
                            hi3[a] = corner_pick();
                        end
                    endcase
                end
                b.min_x = lo3[0];
                b.min_y = lo3[1];
                b.min_z = lo3[2];
                b.max_x = hi3[0];
                b.max_y = hi3[1];
                b.max_z = hi3[2];
                case ($urandom_range(0, 7))
                    0: b.mask = '0;
                    1: b.mask = 32'h1 << $urandom_range(0, 31);
                    2: b.mask = '1;
                    default: b.mask = $urandom();
                endcase
                send_box(b, 1'b0, VIS_UNKNOWN);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_vis.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("%0d boxes over a directed script and %0d random views", n_boxes, RAND_VIEWS);
        $display("results seen: %0d unknown, %0d visible, %0d hidden",
                 n_class[VIS_UNKNOWN], n_class[VIS_VISIBLE], n_class[VIS_HIDDEN]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/afv_pkg.sv
rtl/core/afv_plane_test.sv
rtl/core/aabb_frustum_visibility.sv
tb/tb_aabb_frustum_visibility.sv
